/* hw/rtl/ijtl_pkg.sv */
// ----------------------------------------------------------------------------
// ijtl_pkg
// Shared constants, config register codes, stage payload types and the
// gain slot lookup for the joint impedance torque law pipeline.
// ----------------------------------------------------------------------------
package ijtl_pkg;

    localparam int JOINTS_DEF = 7;
    localparam int GAIN_SLOTS = 7;

    // filter weights in Q0.16, 0.99 and 0.01
    localparam logic signed [17:0] ALPHA_Q16           = 18'sd64881;
    localparam logic signed [10:0] ONE_MINUS_ALPHA_Q16 = 11'sd655;

    localparam logic [15:0] COR_SCALE_RST = 16'd16384;
    localparam logic [30:0] MAX_STEP_RST  = 31'd65536;

    typedef enum logic [2:0] {
        CFG_K_LO      = 3'd0,
        CFG_K_HI      = 3'd1,
        CFG_D_LO      = 3'd2,
        CFG_D_HI      = 3'd3,
        CFG_COR_SCALE = 3'd4,
        CFG_MAX_STEP  = 3'd5
    } t_cfg_idx;

    // front end -> filter stage
    typedef struct packed {
        logic [2:0]          joint;
        logic signed [48:0]  pdq;    // ALPHA * velocity
        logic signed [48:0]  pcor;   // coriolis_scale * coriolis_torque
        logic signed [32:0]  eq;     // position_target - position
        logic signed [31:0]  dqd;
        logic signed [31:0]  prev;
        logic [15:0]         k;
        logic [15:0]         d;
    } t_front_item;

    // filter stage -> torque law stages
    typedef struct packed {
        logic [2:0]          joint;
        logic signed [31:0]  fv;
        logic signed [31:0]  dqd;
        logic signed [31:0]  prev;
        logic signed [34:0]  cor;    // rounded Coriolis term, Q16.16
        logic signed [49:0]  kterm;
        logic [15:0]         d;
    } t_filt_item;

    function automatic logic [15:0] gain_of(input logic [63:0] lo,
                                            input logic [47:0] hi,
                                            input logic [2:0]  j);
        logic [15:0] g;
        case (j)
            3'd0:    g = lo[15:0];
            3'd1:    g = lo[31:16];
            3'd2:    g = lo[47:32];
            3'd3:    g = lo[63:48];
            3'd4:    g = hi[15:0];
            3'd5:    g = hi[31:16];
            3'd6:    g = hi[47:32];
            default: g = 16'd0;
        endcase
        return g;
    endfunction

endpackage

/* hw/rtl/ijtl_front.sv */
// ----------------------------------------------------------------------------
// ijtl_front
// Input capture and first product stage: velocity and Coriolis products,
// position error and gain slot selection.
// ----------------------------------------------------------------------------
module ijtl_front
    import ijtl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_joint,
    input  logic [191:0]        i_data,     // q, q_d, dq, dq_d, prev, coriolis
    input  logic [63:0]         i_k_lo,
    input  logic [47:0]         i_k_hi,
    input  logic [63:0]         i_d_lo,
    input  logic [47:0]         i_d_hi,
    input  logic [15:0]         i_cor_scale,
    output logic                o_valid,
    input  logic                i_ready,
    output t_front_item         o_item
);

    logic               r_v1;
    logic [2:0]         r_j1;
    logic signed [31:0] r_q1, r_qd1, r_dq1, r_dqd1, r_prev1, r_cor1;
    logic               r_v2;
    t_front_item        r_s2;
    t_front_item        n_s2;
    logic               w_rdy1, w_rdy2;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
        if (w_rdy1 && i_valid) begin
            r_j1    <= i_joint;
            r_q1    <= $signed(i_data[31:0]);
            r_qd1   <= $signed(i_data[63:32]);
            r_dq1   <= $signed(i_data[95:64]);
            r_dqd1  <= $signed(i_data[127:96]);
            r_prev1 <= $signed(i_data[159:128]);
            r_cor1  <= $signed(i_data[191:160]);
        end
    end

    always_comb begin
        n_s2.joint = r_j1;
        n_s2.pdq   = ALPHA_Q16 * r_dq1;
        n_s2.pcor  = $signed({1'b0, i_cor_scale}) * r_cor1;
        n_s2.eq    = r_qd1 - r_q1;
        n_s2.dqd   = r_dqd1;
        n_s2.prev  = r_prev1;
        n_s2.k     = gain_of(i_k_lo, i_k_hi, r_j1);
        n_s2.d     = gain_of(i_d_lo, i_d_hi, r_j1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (w_rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_s2;

    // joints without a gain slot carry zero gains
    a_no_slot_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (r_s2.joint >= 3'(GAIN_SLOTS))) |-> (r_s2.k == '0 && r_s2.d == '0))
        else $error("gain selected for joint without slot");

endmodule

/* hw/rtl/ijtl_filter.sv */
// ----------------------------------------------------------------------------
// ijtl_filter
// Per-joint velocity low-pass state. The state is read and written in the
// same stage, so a sample of the same joint right behind sees the update.
// Also forms the rounded Coriolis term and the stiffness product.
// ----------------------------------------------------------------------------
module ijtl_filter
    import ijtl_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_front_item         i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output t_filt_item          o_item
);

    localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    logic [JOINTS-1:0][31:0] r_fv;
    logic                    r_v3;
    t_filt_item              r_s3;
    t_filt_item              n_s3;
    logic                    w_rdy3;
    logic                    w_load;
    logic                    w_in_range;
    logic [IW-1:0]           w_idx;
    logic signed [31:0]      w_old;
    logic signed [49:0]      w_acc;
    logic signed [48:0]      w_cor_sum;

    assign w_rdy3     = !r_v3 || i_ready;
    assign o_ready    = w_rdy3;
    assign w_load     = w_rdy3 && i_valid;
    assign w_in_range = 5'(i_item.joint) < 5'(JOINTS);
    assign w_idx      = IW'(i_item.joint);
    assign w_old      = w_in_range ? $signed(r_fv[w_idx]) : 32'sd0;

    // fv' = (655*old + 64881*dq + 2^15) >> 16; the weights sum to 1, so it fits
    assign w_acc     = (ONE_MINUS_ALPHA_Q16 * w_old) + i_item.pdq + 50'sd32768;
    assign w_cor_sum = i_item.pcor + 49'sd8192;

    always_comb begin
        n_s3.joint = i_item.joint;
        n_s3.fv    = w_in_range ? $signed(w_acc[47:16]) : 32'sd0;
        n_s3.dqd   = i_item.dqd;
        n_s3.prev  = i_item.prev;
        n_s3.cor   = $signed(w_cor_sum[48:14]);
        n_s3.kterm = $signed({1'b0, i_item.k}) * i_item.eq;
        n_s3.d     = w_in_range ? i_item.d : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_fv <= '0;
        end else begin
            if (w_rdy3) begin
                r_v3 <= i_valid;
            end
            if (w_load && w_in_range) begin
                r_fv[w_idx] <= n_s3.fv;
            end
        end
        if (w_load) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_s3;

    a_out_of_range_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_in_range) |=> $stable(r_fv))
        else $error("filter state changed for joint beyond range");

    a_reset_clears_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_fv == '0))
        else $error("filter state not cleared by reset");

endmodule

/* hw/rtl/ijtl_law.sv */
// ----------------------------------------------------------------------------
// ijtl_law
// Damping product, torque sum, step clamp against the previous command and
// 32-bit saturation. Five register stages, the last one drives the output.
// ----------------------------------------------------------------------------
module ijtl_law
    import ijtl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_filt_item          i_item,
    input  logic [30:0]         i_max_step,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_joint,
    output logic signed [31:0]  o_torque,
    output logic                o_rate_limited
);

    // stage 4: velocity error, partial sum
    logic               r_v4;
    logic [2:0]         r_j4;
    logic signed [32:0] r_ev4;
    logic signed [50:0] r_s4;
    logic [15:0]        r_d4;
    logic signed [31:0] r_prev4;
    // stage 5: damping product
    logic               r_v5;
    logic [2:0]         r_j5;
    logic signed [49:0] r_dterm5;
    logic signed [50:0] r_s5;
    logic signed [31:0] r_prev5;
    // stage 6: step from previous command
    logic               r_v6;
    logic [2:0]         r_j6;
    logic signed [52:0] r_diff6;
    logic signed [31:0] r_prev6;
    // stage 7: clamped step
    logic               r_v7;
    logic [2:0]         r_j7;
    logic signed [31:0] r_dc7;
    logic               r_clamp7;
    logic signed [31:0] r_prev7;
    // stage 8: output
    logic               r_v8;
    logic [2:0]         r_j8;
    logic signed [31:0] r_cmd8;
    logic               r_clamp8;

    logic               w_rdy4, w_rdy5, w_rdy6, w_rdy7, w_rdy8;
    logic signed [52:0] w_lim;
    logic signed [52:0] w_step;
    logic               w_clamp;
    logic signed [32:0] w_cmd;
    logic signed [31:0] w_cmd_sat;

    assign w_rdy8  = !r_v8 || i_ready;
    assign w_rdy7  = !r_v7 || w_rdy8;
    assign w_rdy6  = !r_v6 || w_rdy7;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign o_ready = w_rdy4;

    assign w_lim = $signed({22'd0, i_max_step});

    always_comb begin
        w_clamp = 1'b1;
        if (r_diff6 > w_lim) begin
            w_step = w_lim;
        end else if (r_diff6 < -w_lim) begin
            w_step = -w_lim;
        end else begin
            w_step  = r_diff6;
            w_clamp = 1'b0;
        end
    end

    assign w_cmd = r_prev7 + r_dc7;

    always_comb begin
        if (w_cmd[32] != w_cmd[31]) begin
            w_cmd_sat = w_cmd[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_cmd_sat = w_cmd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (w_rdy4) r_v4 <= i_valid;
            if (w_rdy5) r_v5 <= r_v4;
            if (w_rdy6) r_v6 <= r_v5;
            if (w_rdy7) r_v7 <= r_v6;
            if (w_rdy8) r_v8 <= r_v7;
        end
        if (w_rdy4 && i_valid) begin
            r_j4    <= i_item.joint;
            r_ev4   <= i_item.dqd - i_item.fv;
            r_s4    <= i_item.cor + i_item.kterm;
            r_d4    <= i_item.d;
            r_prev4 <= i_item.prev;
        end
        if (w_rdy5 && r_v4) begin
            r_j5     <= r_j4;
            r_dterm5 <= $signed({1'b0, r_d4}) * r_ev4;
            r_s5     <= r_s4;
            r_prev5  <= r_prev4;
        end
        if (w_rdy6 && r_v5) begin
            r_j6    <= r_j5;
            r_diff6 <= r_s5 + r_dterm5 - r_prev5;
            r_prev6 <= r_prev5;
        end
        if (w_rdy7 && r_v6) begin
            r_j7     <= r_j6;
            r_dc7    <= w_step[31:0];
            r_clamp7 <= w_clamp;
            r_prev7  <= r_prev6;
        end
        if (w_rdy8 && r_v7) begin
            r_j8     <= r_j7;
            r_cmd8   <= w_cmd_sat;
            r_clamp8 <= r_clamp7;
        end
    end

    assign o_valid        = r_v8;
    assign o_joint        = r_j8;
    assign o_torque       = r_cmd8;
    assign o_rate_limited = r_clamp8;

    // an unclamped step passes through stage 7 unchanged
    a_unclamped_step_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rdy7 && r_v6 && !w_clamp) |=> (r_dc7 == $past(r_diff6[31:0])))
        else $error("unclamped step altered");

endmodule

/* hw/rtl/joint_impedance_torque_law_unit.sv */
// ----------------------------------------------------------------------------
// joint_impedance_torque_law_unit
// Joint impedance torque law with per-joint velocity filter and torque step
// limit, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one joint sample per transaction; tuser carries the joint
//   index, tdata the six Q16.16 words. Master stream: one torque command per
//   sample, in order; tuser carries joint index and the clamp flag.
//   Config channel: register index and data, always ready; write only while
//   no sample is in flight.
//   One sample is accepted per cycle unless a stalled master side has filled
//   the pipeline, also for the same joint back to back: the filter state is
//   read and updated in a single stage.
//   Pipeline is 8 register stages with per-stage valids; bubbles close up and
//   a stalled master side holds the last stage while earlier stages keep
//   filling, so tready drops only once every stage holds a sample.
//   Reset (synchronous, active low) empties the pipeline, clears the filtered
//   velocities and loads the register reset values (gains 0, Coriolis scale
//   1.0, max step 1.0).
// ----------------------------------------------------------------------------
module joint_impedance_torque_law_unit
    import ijtl_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // sample in
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // position, position_target, velocity, velocity_target,
    // previous_torque, coriolis_torque (32 bits each, lowest first)
    input  logic [191:0]  i_s_axis_tdata,
    input  logic [2:0]    i_s_axis_tuser,   // joint
    // command out
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [31:0]   o_m_axis_tdata,   // torque_command
    output logic [3:0]    o_m_axis_tuser,   // joint_out [2:0], rate_limited [3]
    // configuration
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);

    logic [63:0]        r_k_lo;
    logic [47:0]        r_k_hi;
    logic [63:0]        r_d_lo;
    logic [47:0]        r_d_hi;
    logic [15:0]        r_cor_scale;
    logic [30:0]        r_max_step;

    logic               w_fr_valid, w_fr_ready;
    t_front_item        w_fr_item;
    logic               w_fl_valid, w_fl_ready;
    t_filt_item         w_fl_item;
    logic [2:0]         w_joint;
    logic signed [31:0] w_torque;
    logic               w_rate_limited;
    logic               w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_lo      <= '0;
            r_k_hi      <= '0;
            r_d_lo      <= '0;
            r_d_hi      <= '0;
            r_cor_scale <= COR_SCALE_RST;
            r_max_step  <= MAX_STEP_RST;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_K_LO:      r_k_lo      <= i_cfg_data;
                CFG_K_HI:      r_k_hi      <= i_cfg_data[47:0];
                CFG_D_LO:      r_d_lo      <= i_cfg_data;
                CFG_D_HI:      r_d_hi      <= i_cfg_data[47:0];
                CFG_COR_SCALE: r_cor_scale <= i_cfg_data[15:0];
                CFG_MAX_STEP:  r_max_step  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    ijtl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_joint     (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata),
        .i_k_lo      (r_k_lo),
        .i_k_hi      (r_k_hi),
        .i_d_lo      (r_d_lo),
        .i_d_hi      (r_d_hi),
        .i_cor_scale (r_cor_scale),
        .o_valid     (w_fr_valid),
        .i_ready     (w_fr_ready),
        .o_item      (w_fr_item)
    );

    ijtl_filter #(
        .JOINTS (JOINTS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_item  (w_fr_item),
        .o_valid (w_fl_valid),
        .i_ready (w_fl_ready),
        .o_item  (w_fl_item)
    );

    ijtl_law u_law (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_fl_valid),
        .o_ready        (w_fl_ready),
        .i_item         (w_fl_item),
        .i_max_step     (r_max_step),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_joint        (w_joint),
        .o_torque       (w_torque),
        .o_rate_limited (w_rate_limited)
    );

    assign o_m_axis_tdata = w_torque;
    assign o_m_axis_tuser = {w_rate_limited, w_joint};

    // writes beyond the register list leave every register as it was
    a_unknown_index_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && (i_cfg_index > CFG_MAX_STEP))
        |=> ($stable(r_k_lo) && $stable(r_k_hi) && $stable(r_d_lo) && $stable(r_d_hi)
             && $stable(r_cor_scale) && $stable(r_max_step)))
        else $error("config write to unknown index changed a register");

endmodule
